FILE: rtl/core/smq_pkg.sv
// Shared types and constants of the selective message queue.
// Used by smq_store and selective_message_queue; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package smq_pkg;

  localparam int ACTION_W  = 8;
  localparam int SOURCE_W  = 64;
  localparam int HANDLE_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int MASK_W    = 64;
  localparam int MASK_N    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_SEL_W = 2;
  localparam int BIT_SEL_W  = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_REJECT  = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SOURCE_W-1:0] source;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/selective_message_queue.sv
// Selective message queue: top level with sequencer, policy masks and output register.
// Push: settled on transfer, then passed through S_DONE to the output register.
// Pull: S_SCAN and S_CMP per entry scanned, then S_SHRD and S_SHWR per later entry moved down.
// One item is worked on at a time; the entry memory's single read port sets the pace.
// Synchronous active-low reset empties the store and clears all drop masks at once.
// Depends on smq_pkg and smq_store.
`timescale 1ns / 1ps
`default_nettype none

module selective_message_queue
  import smq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [ACTION_W-1:0]  in_action,
  input  wire logic [SOURCE_W-1:0]  in_source,
  input  wire logic [HANDLE_W-1:0]  in_message_handle,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic [HANDLE_W-1:0]       out_found_handle,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer and working registers.
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [SOURCE_W-1:0]   src_r, src_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0]   res_handle_r, res_handle_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;

  // Drop policy, one bit per action class.
  logic [MASK_N-1:0][MASK_W-1:0] drop_mask_r;

  // Memory port signals.
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  entry_t                wr_data;
  logic [ADDR_W-1:0]     rd_addr;
  entry_t                rd_data;

  logic                  in_xfer;
  logic                  out_free;
  logic                  is_dropped;
  logic                  is_match;
  logic [CNT_W-1:0]      idx_inc;

  smq_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The block takes a new item only when the sequencer is idle; a finished
  // result may still be waiting in the output register at that time.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign is_dropped = drop_mask_r[in_action[ACTION_W-1 -: WORD_SEL_W]][in_action[BIT_SEL_W-1:0]];

  // The one shared compare: the stored entry against the wanted action and
  // source, where a wanted source of zero matches any sender.
  assign is_match = (rd_data.action == act_r) &&
                    ((src_r == '0) || (rd_data.source == src_r));

  assign idx_inc = idx_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      drop_mask_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    act_r        <= act_nxt;
    src_r        <= src_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    src_nxt        = src_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[ADDR_W-1:0];
    wr_data        = '{action: in_action, source: in_source, handle: in_message_handle};
    rd_addr        = idx_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt        = in_action;
          src_nxt        = in_source;
          idx_nxt        = '0;
          res_handle_nxt = '0;
          if (in_mode == 1'b0) begin
            // Push is settled at once: the null check precedes the policy check.
            state_nxt = S_DONE;
            if (in_message_handle == '0) begin
              res_status_nxt = ST_REJECT;
            end else if (is_dropped) begin
              res_status_nxt = ST_DROPPED;
            end else if (count_r >= CAP_CNT) begin
              res_status_nxt = ST_REJECT;
            end else begin
              wr_en          = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              res_status_nxt = ST_DONE;
            end
          end else begin
            res_status_nxt = ST_NOMATCH;
            state_nxt      = (count_r == '0) ? S_DONE : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read of entry idx is issued here; its data is compared next cycle.
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (is_match) begin
          res_handle_nxt = rd_data.handle;
          res_status_nxt = ST_DONE;
          state_nxt      = S_SHRD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == count_r) ? S_DONE : S_SCAN;
        end
      end

      S_SHRD: begin
        // Close the gap left by the removed entry, one entry at a time: read in S_SHRD, write in S_SHWR.
        if (idx_inc < count_r) begin
          rd_addr   = idx_inc[ADDR_W-1:0];
          state_nxt = S_SHWR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[ADDR_W-1:0];
        wr_data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = S_SHRD;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_handle_r;

endmodule

`default_nettype wire

FILE: rtl/core/smq_store.sv
// Entry memory of the selective message queue: one write port, one read port
// with registered read data. Depends on smq_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module smq_store
  import smq_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
